### design/fec_pkg.sv
// ----------------------------------------------------------------------------
// fec_pkg: shared constants and helpers for the fail-safe escalation block
// Level, status, opcode, stop and register index codes, reset values of the
// configuration registers, and the fixed severity rank of each cause code.
// ----------------------------------------------------------------------------
package fec_pkg;

    // Event opcodes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_TRIGGER   = 2'd1;
    localparam logic [1:0] OP_MAN_RESET = 2'd2;
    localparam logic [1:0] OP_INIT_DONE = 2'd3;

    // Supervisor levels, ordered by escalation
    localparam logic [2:0] LV_INIT  = 3'd0;
    localparam logic [2:0] LV_SAFE  = 3'd1;
    localparam logic [2:0] LV_WARN  = 3'd2;
    localparam logic [2:0] LV_FAULT = 3'd3;
    localparam logic [2:0] LV_EMERG = 3'd4;
    localparam logic [2:0] LV_CRIT  = 3'd5;

    // Result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_INIT  = 2'd1;
    localparam logic [1:0] ST_BAD_PARAM = 2'd2;
    localparam logic [1:0] ST_HEALTH    = 2'd3;

    // Stop requests
    localparam logic [1:0] STOP_NONE  = 2'd0;
    localparam logic [1:0] STOP_CTRL  = 2'd1;
    localparam logic [1:0] STOP_EMERG = 2'd2;

    // Trigger codes
    localparam logic [3:0] TC_NONE      = 4'd0;
    localparam logic [3:0] TC_ESTOP     = 4'd1;
    localparam logic [3:0] TC_TIMING    = 4'd2;
    localparam logic [3:0] TC_OVERCUR   = 4'd3;
    localparam logic [3:0] TC_WATCHDOG  = 4'd4;
    localparam logic [3:0] TC_POWER     = 4'd5;
    localparam logic [3:0] TC_POSITION  = 4'd6;
    localparam logic [3:0] TC_TEMP      = 4'd7;
    localparam logic [3:0] TC_COMMS     = 4'd8;
    localparam logic [3:0] TC_SENSOR    = 4'd9;
    localparam logic [3:0] TC_SYSTEM    = 4'd10;

    // Configuration register indexes
    localparam logic [2:0] CFG_INIT_TO   = 3'd0;
    localparam logic [2:0] CFG_WARN_TO   = 3'd1;
    localparam logic [2:0] CFG_STOP_TO   = 3'd2;
    localparam logic [2:0] CFG_MAX_RECOV = 3'd3;
    localparam logic [2:0] CFG_CRIT_SEV  = 3'd4;
    localparam logic [2:0] CFG_FAULT_SEV = 3'd5;

    // Configuration reset values
    localparam logic [31:0] RST_INIT_TO   = 32'd10000;
    localparam logic [31:0] RST_WARN_TO   = 32'd5000;
    localparam logic [31:0] RST_STOP_TO   = 32'd2000;
    localparam logic [7:0]  RST_MAX_RECOV = 8'd3;
    localparam logic [7:0]  RST_CRIT_SEV  = 8'd8;
    localparam logic [7:0]  RST_FAULT_SEV = 8'd7;

    function automatic logic [3:0] cause_rank(input logic [3:0] code);
        logic [3:0] rank;
        case (code)
            TC_ESTOP: rank = 4'd10;
            TC_TIMING, TC_WATCHDOG, TC_POWER: rank = 4'd9;
            TC_OVERCUR, TC_POSITION: rank = 4'd7;
            TC_TEMP, TC_COMMS: rank = 4'd5;
            TC_SENSOR: rank = 4'd4;
            default: rank = 4'd2;
        endcase
        return rank;
    endfunction

endpackage

### design/failsafe_escalation_controller.sv
// ----------------------------------------------------------------------------
// failsafe_escalation_controller
// Six-level fail-safe supervisor: takes tick, trigger, manual reset and init
// done events and reports level, cause, latched flags and issued actions.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | opcode, trigger_code, severity,
//          |           |                           | elapsed_ms, health_ok
//  out     | output    | o_out_valid / i_out_ready | status .. faults_seen
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One event per cycle while the result is taken: the event waits in the input
//  register, and the state update and the result register load at the same edge.
//  An accepted event passes the input register, then the output register.
//  A stalled result holds the output register; the input register still
//  takes a beat and waits there. The configuration port never stalls.
//  Reset (synchronous, active low) returns the supervisor to init, not ready.
// ----------------------------------------------------------------------------
module failsafe_escalation_controller
    import fec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_trigger_code,
    input  logic [7:0]  i_severity,
    input  logic [15:0] i_elapsed_ms,
    input  logic        i_health_ok,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [2:0]  o_level,
    output logic [3:0]  o_cause_code,
    output logic [3:0]  o_cause_severity,
    output logic        o_can_recover,
    output logic        o_needs_manual_reset,
    output logic        o_hw_failsafe_on,
    output logic        o_relays_closed,
    output logic [1:0]  o_stop_request,
    output logic        o_slow_down,
    output logic        o_warn_lamp,
    output logic [31:0] o_faults_seen,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // configuration
    logic [31:0] r_init_to, r_warn_to, r_stop_to;
    logic [7:0]  r_max_recov, r_crit_sev, r_fault_sev;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [3:0]  r_code;
    logic [7:0]  r_sev;
    logic [15:0] r_elapsed;
    logic        r_healthy;

    // supervisor state
    logic        r_ready;
    logic [2:0]  r_level;
    logic [3:0]  r_cause;
    logic [31:0] r_time;
    logic [7:0]  r_tries;
    logic        r_manual;
    logic        r_latch;
    logic        r_relay;
    logic [31:0] r_tally;

    logic        n_ready;
    logic [2:0]  n_level;
    logic [3:0]  n_cause;
    logic [31:0] n_time;
    logic [7:0]  n_tries;
    logic        n_manual;
    logic        n_latch;
    logic        n_relay;
    logic [31:0] n_tally;

    // event results
    logic [1:0]  n_status;
    logic [1:0]  n_stop;
    logic        n_slow;
    logic        n_lamp;
    logic        n_can_recover;

    // output register
    logic        r_out_valid;

    logic        advance;

    // scratch for the event logic
    logic        ent;
    logic [2:0]  ent_lv;
    logic [3:0]  ent_cause;
    logic [2:0]  from_lv;
    logic [32:0] t_sum;
    logic [31:0] t_limit;
    logic        t_over;
    logic        recov;
    logic [2:0]  target;
    logic [7:0]  tries_inc;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_to   <= RST_INIT_TO;
            r_warn_to   <= RST_WARN_TO;
            r_stop_to   <= RST_STOP_TO;
            r_max_recov <= RST_MAX_RECOV;
            r_crit_sev  <= RST_CRIT_SEV;
            r_fault_sev <= RST_FAULT_SEV;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INIT_TO:   r_init_to   <= i_cfg_data;
                CFG_WARN_TO:   r_warn_to   <= i_cfg_data;
                CFG_STOP_TO:   r_stop_to   <= i_cfg_data;
                CFG_MAX_RECOV: r_max_recov <= i_cfg_data[7:0];
                CFG_CRIT_SEV:  r_crit_sev  <= i_cfg_data[7:0];
                CFG_FAULT_SEV: r_fault_sev <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op      <= i_opcode;
            r_code    <= i_trigger_code;
            r_sev     <= i_severity;
            r_elapsed <= i_elapsed_ms;
            r_healthy <= i_health_ok;
        end
    end

    always_comb begin
        n_ready   = r_ready;
        n_level   = r_level;
        n_cause   = r_cause;
        n_time    = r_time;
        n_tries   = r_tries;
        n_manual  = r_manual;
        n_latch   = r_latch;
        n_relay   = r_relay;
        n_tally   = r_tally;
        n_status  = ST_OK;
        n_stop    = STOP_NONE;
        n_slow    = 1'b0;
        n_lamp    = 1'b0;
        ent       = 1'b0;
        ent_lv    = LV_SAFE;
        ent_cause = TC_NONE;
        from_lv   = r_level;
        target    = LV_WARN;
        tries_inc = (r_tries == 8'hFF) ? r_tries : r_tries + 8'd1;

        recov = (r_tries < r_max_recov) && !r_latch && !r_manual &&
                (r_level == LV_WARN || r_level == LV_FAULT);

        t_sum  = {1'b0, r_time} + {17'd0, r_elapsed};
        case (r_level)
            LV_INIT: t_limit = r_init_to;
            LV_WARN: t_limit = r_warn_to;
            default: t_limit = r_stop_to;
        endcase
        t_over = (t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0]) > t_limit;

        case (r_op)
            OP_INIT_DONE: begin
                if (!r_ready) begin
                    // restart from a clean slate with relays closed
                    n_level  = LV_INIT;
                    n_cause  = TC_NONE;
                    n_time   = '0;
                    n_tries  = '0;
                    n_manual = 1'b0;
                    n_latch  = 1'b0;
                    n_relay  = 1'b1;
                    n_tally  = '0;
                    from_lv  = LV_INIT;
                    ent      = 1'b1;
                    if (!r_healthy) begin
                        ent_lv    = LV_CRIT;
                        ent_cause = TC_SYSTEM;
                        n_status  = ST_HEALTH;
                    end else begin
                        n_ready   = 1'b1;
                        ent_lv    = LV_SAFE;
                        ent_cause = TC_NONE;
                    end
                end
            end
            OP_TICK: begin
                if (!r_ready) begin
                    n_status = ST_NOT_INIT;
                end else begin
                    n_time = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
                    case (r_level)
                        LV_WARN:  n_slow = 1'b1;
                        LV_FAULT: n_lamp = 1'b1;
                        LV_EMERG: begin
                            n_relay = 1'b0;
                            n_latch = 1'b1;
                        end
                        LV_CRIT:  n_manual = 1'b1;
                        default: ;
                    endcase
                    if (r_level == LV_INIT && t_over) begin
                        ent       = 1'b1;
                        ent_lv    = LV_FAULT;
                        ent_cause = TC_SYSTEM;
                    end else if (r_level == LV_WARN && t_over) begin
                        ent       = 1'b1;
                        ent_lv    = LV_FAULT;
                        ent_cause = r_cause;
                    end else if (r_level == LV_FAULT && t_over && !recov) begin
                        ent       = 1'b1;
                        ent_lv    = LV_EMERG;
                        ent_cause = r_cause;
                    end else if (r_level == LV_WARN && r_healthy && recov) begin
                        if (tries_inc > r_max_recov) begin
                            n_tries  = tries_inc;
                            n_manual = 1'b1;
                        end else begin
                            n_tries   = '0;
                            ent       = 1'b1;
                            ent_lv    = LV_SAFE;
                            ent_cause = TC_NONE;
                        end
                    end
                end
            end
            OP_TRIGGER: begin
                if (!r_ready) begin
                    n_status = ST_NOT_INIT;
                end else if (r_code > TC_SYSTEM) begin
                    n_status = ST_BAD_PARAM;
                end else begin
                    if (r_code == TC_ESTOP) begin
                        target = LV_EMERG;
                    end else if (r_code >= TC_TIMING && r_code <= TC_POWER) begin
                        target = (r_sev >= r_crit_sev) ? LV_CRIT : LV_FAULT;
                    end else if (r_code >= TC_POSITION && r_code <= TC_SENSOR) begin
                        target = (r_sev >= r_fault_sev) ? LV_FAULT : LV_WARN;
                    end
                    // escalate only
                    if (target > r_level) begin
                        ent       = 1'b1;
                        ent_lv    = target;
                        ent_cause = r_code;
                    end
                end
            end
            default: begin
                if (!r_ready) begin
                    n_status = ST_NOT_INIT;
                end else if (!r_healthy) begin
                    n_status = ST_HEALTH;
                end else begin
                    n_tries   = '0;
                    n_manual  = 1'b0;
                    n_latch   = 1'b0;
                    ent       = 1'b1;
                    ent_lv    = LV_SAFE;
                    ent_cause = TC_NONE;
                end
            end
        endcase

        // level entry and its actions
        if (ent) begin
            if (from_lv == LV_SAFE) begin
                n_lamp = 1'b1;
            end
            n_level = ent_lv;
            n_cause = ent_cause;
            n_time  = '0;
            case (ent_lv)
                LV_WARN:  n_lamp = 1'b1;
                LV_FAULT: n_stop = STOP_CTRL;
                LV_EMERG: n_stop = STOP_EMERG;
                LV_CRIT: begin
                    n_relay = 1'b0;
                    n_latch = 1'b1;
                end
                default: ;
            endcase
            if (ent_lv >= LV_FAULT && n_tally != 32'hFFFF_FFFF) begin
                n_tally = n_tally + 32'd1;
            end
        end

        n_can_recover = (n_tries < r_max_recov) && !n_latch && !n_manual &&
                        (n_level == LV_WARN || n_level == LV_FAULT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready  <= 1'b0;
            r_level  <= LV_INIT;
            r_cause  <= TC_NONE;
            r_time   <= '0;
            r_tries  <= '0;
            r_manual <= 1'b0;
            r_latch  <= 1'b0;
            r_relay  <= 1'b0;
            r_tally  <= '0;
        end else if (advance) begin
            r_ready  <= n_ready;
            r_level  <= n_level;
            r_cause  <= n_cause;
            r_time   <= n_time;
            r_tries  <= n_tries;
            r_manual <= n_manual;
            r_latch  <= n_latch;
            r_relay  <= n_relay;
            r_tally  <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_status             <= n_status;
            o_level              <= n_level;
            o_cause_code         <= n_cause;
            o_cause_severity     <= cause_rank(n_cause);
            o_can_recover        <= n_can_recover;
            o_needs_manual_reset <= n_manual;
            o_hw_failsafe_on     <= n_latch;
            o_relays_closed      <= n_relay;
            o_stop_request       <= n_stop;
            o_slow_down          <= n_slow;
            o_warn_lamp          <= n_lamp;
            o_faults_seen        <= n_tally;
        end
    end

endmodule

### design/fec_checker.sv
// ----------------------------------------------------------------------------
// fec_port_checks: port-level checks for the fail-safe escalation block
// Watches the result channel for consistency of the reported flags.
// ----------------------------------------------------------------------------
module fec_port_checks
    import fec_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_level,
    input logic        o_can_recover,
    input logic        o_needs_manual_reset,
    input logic        o_hw_failsafe_on,
    input logic        o_relays_closed,
    input logic [1:0]  o_stop_request
);

    // a stalled beat holds its level
    a_hold_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_level))
        else $error("result level changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // the latch only sets together with opening the relays
    a_latch_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hw_failsafe_on |-> !o_relays_closed)
        else $error("fail-safe latched with relays closed");

    a_recover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_can_recover |->
            (o_level == LV_WARN || o_level == LV_FAULT) &&
            !o_needs_manual_reset && !o_hw_failsafe_on)
        else $error("recovery reported where it is barred");

    a_estop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stop_request == STOP_EMERG |-> o_level == LV_EMERG)
        else $error("emergency stop outside emergency level");

endmodule

bind failsafe_escalation_controller fec_port_checks u_fec_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_level              (o_level),
    .o_can_recover        (o_can_recover),
    .o_needs_manual_reset (o_needs_manual_reset),
    .o_hw_failsafe_on     (o_hw_failsafe_on),
    .o_relays_closed      (o_relays_closed),
    .o_stop_request       (o_stop_request)
);

### dv/fec_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fec_checker: result predictor and scoreboard for the escalation supervisor
// Watches the event, result and configuration channels. Every event beat is
// run through a cycle-free model of the supervisor and the predicted report
// is queued; every result beat is compared field by field with the oldest
// queued report. Mismatch and pending counts go back to the testbench top.
// ----------------------------------------------------------------------------
module fec_checker
    import fec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_trigger_code,
    input  logic [7:0]  i_severity,
    input  logic [15:0] i_elapsed_ms,
    input  logic        i_health_ok,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [2:0]  i_level,
    input  logic [3:0]  i_cause_code,
    input  logic [3:0]  i_cause_severity,
    input  logic        i_can_recover,
    input  logic        i_needs_manual_reset,
    input  logic        i_hw_failsafe_on,
    input  logic        i_relays_closed,
    input  logic [1:0]  i_stop_request,
    input  logic        i_slow_down,
    input  logic        i_warn_lamp,
    input  logic [31:0] i_faults_seen,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  level;
        logic [3:0]  cause;
        logic [3:0]  rank;
        logic        can_recover;
        logic        manual;
        logic        latch;
        logic        relays;
        logic [1:0]  stop;
        logic        slow;
        logic        lamp;
        logic [31:0] faults;
    } sup_report_t;

    sup_report_t report_q[$];
    int          mismatches = 0;

    // configuration
    logic [31:0] init_to, warn_to, stop_to;
    logic [7:0]  max_tries, crit_sev, fault_sev;

    // supervisor state
    logic        armed;
    logic [2:0]  lvl;
    logic [3:0]  cause;
    logic [31:0] dwell;
    logic [7:0]  tries;
    logic        manual, latch, relays;
    logic [31:0] fault_cnt;

    // actions issued by the current event
    logic [1:0]  act_stop;
    logic        act_slow, act_lamp;

    function automatic logic [3:0] rank_of(input logic [3:0] code);
        if (code == TC_ESTOP) return 4'd10;
        if (code == TC_TIMING || code == TC_WATCHDOG || code == TC_POWER) return 4'd9;
        if (code == TC_OVERCUR || code == TC_POSITION) return 4'd7;
        if (code == TC_TEMP || code == TC_COMMS) return 4'd5;
        if (code == TC_SENSOR) return 4'd4;
        return 4'd2;
    endfunction

    function automatic logic recovery_open();
        if (tries >= max_tries || latch || manual) return 1'b0;
        return lvl == LV_WARN || lvl == LV_FAULT;
    endfunction

    function automatic void raise_stop(input logic [1:0] kind);
        if (kind > act_stop) act_stop = kind;
    endfunction

    function automatic void move_to(input logic [2:0] target, input logic [3:0] why);
        if (lvl == LV_SAFE) act_lamp = 1'b1;
        lvl   = target;
        cause = why;
        dwell = '0;
        case (target)
            LV_WARN:  act_lamp = 1'b1;
            LV_FAULT: raise_stop(STOP_CTRL);
            LV_EMERG: raise_stop(STOP_EMERG);
            LV_CRIT: begin
                relays = 1'b0;
                latch  = 1'b1;
            end
            default: ;
        endcase
        if (target >= LV_FAULT && fault_cnt != '1) fault_cnt = fault_cnt + 32'd1;
    endfunction

    function automatic void clear_supervisor();
        armed     = 1'b0;
        lvl       = LV_INIT;
        cause     = TC_NONE;
        dwell     = '0;
        tries     = '0;
        manual    = 1'b0;
        latch     = 1'b0;
        relays    = 1'b0;
        fault_cnt = '0;
    endfunction

    function automatic void run_tick(input logic [15:0] ms, input logic ok);
        logic [32:0] sum;
        sum   = {1'b0, dwell} + {17'd0, ms};
        dwell = sum[32] ? '1 : sum[31:0];
        // periodic action of the level held at the start of the tick
        case (lvl)
            LV_WARN:  act_slow = 1'b1;
            LV_FAULT: act_lamp = 1'b1;
            LV_EMERG: begin
                relays = 1'b0;
                latch  = 1'b1;
            end
            LV_CRIT:  manual = 1'b1;
            default: ;
        endcase
        if (lvl == LV_INIT && dwell > init_to) begin
            move_to(LV_FAULT, TC_SYSTEM);
        end else if (lvl == LV_WARN && dwell > warn_to) begin
            move_to(LV_FAULT, cause);
        end else if (lvl == LV_FAULT && dwell > stop_to && !recovery_open()) begin
            move_to(LV_EMERG, cause);
        end else if (lvl == LV_WARN && ok && recovery_open()) begin
            if (tries != 8'hFF) tries = tries + 8'd1;
            if (tries > max_tries) begin
                manual = 1'b1;
            end else begin
                tries = '0;
                move_to(LV_SAFE, TC_NONE);
            end
        end
    endfunction

    function automatic logic [1:0] run_trigger(input logic [3:0] code, input logic [7:0] sev);
        logic [2:0] target;
        if (code > TC_SYSTEM) return ST_BAD_PARAM;
        if (code == TC_ESTOP)
            target = LV_EMERG;
        else if (code >= TC_TIMING && code <= TC_POWER)
            target = (sev >= crit_sev) ? LV_CRIT : LV_FAULT;
        else if (code >= TC_POSITION && code <= TC_SENSOR)
            target = (sev >= fault_sev) ? LV_FAULT : LV_WARN;
        else
            target = LV_WARN;
        // escalate only upward
        if (target > lvl) move_to(target, code);
        return ST_OK;
    endfunction

    function automatic sup_report_t predict_event(input logic [1:0] op, input logic [3:0] code,
                                                  input logic [7:0] sev, input logic [15:0] ms,
                                                  input logic ok);
        sup_report_t r;
        logic [1:0]  st;
        st       = ST_OK;
        act_stop = STOP_NONE;
        act_slow = 1'b0;
        act_lamp = 1'b0;
        if (op == OP_INIT_DONE) begin
            if (!armed) begin
                clear_supervisor();
                relays = 1'b1;
                if (!ok) begin
                    move_to(LV_CRIT, TC_SYSTEM);
                    st = ST_HEALTH;
                end else begin
                    armed = 1'b1;
                    move_to(LV_SAFE, TC_NONE);
                end
            end
        end else if (!armed) begin
            st = ST_NOT_INIT;
        end else if (op == OP_TICK) begin
            run_tick(ms, ok);
        end else if (op == OP_TRIGGER) begin
            st = run_trigger(code, sev);
        end else if (!ok) begin
            st = ST_HEALTH;
        end else begin
            tries  = '0;
            manual = 1'b0;
            latch  = 1'b0;
            move_to(LV_SAFE, TC_NONE);
        end
        r.status      = st;
        r.level       = lvl;
        r.cause       = cause;
        r.rank        = rank_of(cause);
        r.can_recover = recovery_open();
        r.manual      = manual;
        r.latch       = latch;
        r.relays      = relays;
        r.stop        = act_stop;
        r.slow        = act_slow;
        r.lamp        = act_lamp;
        r.faults      = fault_cnt;
        return r;
    endfunction

    task automatic match_field(input string tag, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, tag, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        sup_report_t want;
        if (!i_rst_n) begin
            init_to   = RST_INIT_TO;
            warn_to   = RST_WARN_TO;
            stop_to   = RST_STOP_TO;
            max_tries = RST_MAX_RECOV;
            crit_sev  = RST_CRIT_SEV;
            fault_sev = RST_FAULT_SEV;
            clear_supervisor();
            report_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INIT_TO:   init_to   = i_cfg_data;
                    CFG_WARN_TO:   warn_to   = i_cfg_data;
                    CFG_STOP_TO:   stop_to   = i_cfg_data;
                    CFG_MAX_RECOV: max_tries = i_cfg_data[7:0];
                    CFG_CRIT_SEV:  crit_sev  = i_cfg_data[7:0];
                    CFG_FAULT_SEV: fault_sev = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // compare before queuing this edge's event: a result never
            // belongs to the event accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with no report pending, level %0d",
                             $time, i_level);
                end else begin
                    want = report_q.pop_front();
                    match_field("status", 32'(want.status), 32'(i_status));
                    match_field("level", 32'(want.level), 32'(i_level));
                    match_field("cause_code", 32'(want.cause), 32'(i_cause_code));
                    match_field("cause_severity", 32'(want.rank),
                                32'(i_cause_severity));
                    match_field("can_recover", 32'(want.can_recover),
                                32'(i_can_recover));
                    match_field("needs_manual_reset", 32'(want.manual),
                                32'(i_needs_manual_reset));
                    match_field("hw_failsafe_on", 32'(want.latch),
                                32'(i_hw_failsafe_on));
                    match_field("relays_closed", 32'(want.relays),
                                32'(i_relays_closed));
                    match_field("stop_request", 32'(want.stop), 32'(i_stop_request));
                    match_field("slow_down", 32'(want.slow), 32'(i_slow_down));
                    match_field("warn_lamp", 32'(want.lamp), 32'(i_warn_lamp));
                    match_field("faults_seen", want.faults, i_faults_seen);
                end
            end
            if (i_in_valid && i_in_ready)
                report_q.push_back(predict_event(i_opcode, i_trigger_code, i_severity,
                                                 i_elapsed_ms, i_health_ok));
        end
        o_errors  <= mismatches;
        o_pending <= report_q.size();
    end

endmodule

### dv/tb_failsafe_escalation_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_failsafe_escalation_controller: testbench top for the escalation block
// Drives a directed walk through every level and special event, then eight
// phases of random events under different register settings, with random
// idling on both channels, one long result stall, and full drains before each
// phase, in the middle of one phase and at the end. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_failsafe_escalation_controller;
    import fec_pkg::*;

    localparam int         LONG_STALL   = 80;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 250;
    localparam logic [3:0] TC_FIRST_BAD = TC_SYSTEM + 4'd1;
    localparam logic [3:0] TC_LAST_BAD  = 4'hF;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_opcode       = OP_TICK;
    logic [3:0]  i_trigger_code = TC_NONE;
    logic [7:0]  i_severity     = '0;
    logic [15:0] i_elapsed_ms   = '0;
    logic        i_health_ok    = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [2:0]  i_cfg_index    = CFG_INIT_TO;
    logic [31:0] i_cfg_data     = '0;

    logic        o_in_ready, o_out_valid, o_cfg_ready;
    logic [1:0]  o_status, o_stop_request;
    logic [2:0]  o_level;
    logic [3:0]  o_cause_code, o_cause_severity;
    logic        o_can_recover, o_needs_manual_reset, o_hw_failsafe_on, o_relays_closed;
    logic        o_slow_down, o_warn_lamp;
    logic [31:0] o_faults_seen;

    int          err_count;
    int          pend_count;
    // long hold-off: requested by the stimulus, served by the result side
    int          choke_req  = 0;
    int          choke_done = 0;
    bit          quiet = 1'b0;
    logic [7:0]  crit_now  = RST_CRIT_SEV;
    logic [7:0]  fault_now = RST_FAULT_SEV;

    failsafe_escalation_controller u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_trigger_code      (i_trigger_code),
        .i_severity          (i_severity),
        .i_elapsed_ms        (i_elapsed_ms),
        .i_health_ok         (i_health_ok),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_level             (o_level),
        .o_cause_code        (o_cause_code),
        .o_cause_severity    (o_cause_severity),
        .o_can_recover       (o_can_recover),
        .o_needs_manual_reset(o_needs_manual_reset),
        .o_hw_failsafe_on    (o_hw_failsafe_on),
        .o_relays_closed     (o_relays_closed),
        .o_stop_request      (o_stop_request),
        .o_slow_down         (o_slow_down),
        .o_warn_lamp         (o_warn_lamp),
        .o_faults_seen       (o_faults_seen),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    fec_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_trigger_code      (i_trigger_code),
        .i_severity          (i_severity),
        .i_elapsed_ms        (i_elapsed_ms),
        .i_health_ok         (i_health_ok),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_status            (o_status),
        .i_level             (o_level),
        .i_cause_code        (o_cause_code),
        .i_cause_severity    (o_cause_severity),
        .i_can_recover       (o_can_recover),
        .i_needs_manual_reset(o_needs_manual_reset),
        .i_hw_failsafe_on    (o_hw_failsafe_on),
        .i_relays_closed     (o_relays_closed),
        .i_stop_request      (o_stop_request),
        .i_slow_down         (o_slow_down),
        .i_warn_lamp         (o_warn_lamp),
        .i_faults_seen       (o_faults_seen),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_errors            (err_count),
        .o_pending           (pend_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("failsafe_escalation_controller verification failed");
        $finish;
    end

    // result side: random stall bursts, or one long hold-off on request
    initial begin : result_side
        forever begin
            @(posedge i_clk);
            if (choke_req != choke_done) begin
                i_out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                choke_done = choke_req;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [3:0] code,
                              input logic [7:0] sev, input logic [15:0] ms, input logic ok);
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_trigger_code <= code;
        i_severity     <= sev;
        i_elapsed_ms   <= ms;
        i_health_ok    <= ok;
        do @(posedge i_clk); while (!o_in_ready);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // drop valid and hold until every queued report has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pend_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_regs(input logic [31:0] init_to, input logic [31:0] warn_to,
                                input logic [31:0] stop_to, input logic [7:0] max_tries,
                                input logic [7:0] crit_sev, input logic [7:0] fault_sev);
        write_reg(CFG_INIT_TO, init_to);
        write_reg(CFG_WARN_TO, warn_to);
        write_reg(CFG_STOP_TO, stop_to);
        write_reg(CFG_MAX_RECOV, {24'd0, max_tries});
        write_reg(CFG_CRIT_SEV, {24'd0, crit_sev});
        write_reg(CFG_FAULT_SEV, {24'd0, fault_sev});
        i_cfg_valid <= 1'b0;
        crit_now  = crit_sev;
        fault_now = fault_sev;
    endtask

    // walk every level and special event under reset settings
    task automatic run_directed();
        send_event(OP_TICK, TC_NONE, 8'd0, 16'd0, 1'b1);
        send_event(OP_TRIGGER, TC_ESTOP, 8'hFF, 16'hFFFF, 1'b1);
        send_event(OP_MAN_RESET, TC_NONE, 8'd0, 16'd0, 1'b1);
        // failed self-test: critical, still not ready
        send_event(OP_INIT_DONE, TC_NONE, 8'd0, 16'd0, 1'b0);
        send_event(OP_INIT_DONE, TC_NONE, 8'd0, 16'd0, 1'b1);
        send_event(OP_INIT_DONE, TC_SENSOR, 8'd0, 16'd0, 1'b0);
        send_event(OP_TRIGGER, TC_FIRST_BAD, 8'd0, 16'd0, 1'b1);
        send_event(OP_TRIGGER, TC_LAST_BAD, 8'hFF, 16'hFFFF, 1'b1);
        send_event(OP_TRIGGER, TC_NONE, 8'd0, 16'd0, 1'b1);
        // exactly at the warning limit, then one past it
        send_event(OP_TICK, TC_NONE, 8'd0, RST_WARN_TO[15:0], 1'b0);
        send_event(OP_TICK, TC_NONE, 8'd0, 16'd1, 1'b0);
        send_event(OP_TRIGGER, TC_POSITION, RST_FAULT_SEV - 8'd1, 16'd0, 1'b1);
        send_event(OP_TICK, TC_NONE, 8'd0, 16'hFFFF, 1'b0);
        send_event(OP_TRIGGER, TC_ESTOP, 8'd0, 16'd0, 1'b1);
        send_event(OP_TICK, TC_NONE, 8'd0, 16'd1, 1'b1);
        send_event(OP_TRIGGER, TC_OVERCUR, RST_CRIT_SEV, 16'd0, 1'b1);
        send_event(OP_TICK, TC_NONE, 8'd0, 16'd1, 1'b1);
        send_event(OP_MAN_RESET, TC_NONE, 8'd0, 16'd0, 1'b0);
        send_event(OP_MAN_RESET, TC_NONE, 8'd0, 16'd0, 1'b1);
        send_event(OP_MAN_RESET, TC_NONE, 8'd0, 16'd0, 1'b1);
        send_event(OP_TRIGGER, TC_TEMP, RST_FAULT_SEV, 16'd0, 1'b1);
        send_event(OP_TRIGGER, TC_TIMING, RST_CRIT_SEV - 8'd1, 16'd0, 1'b1);
        send_event(OP_MAN_RESET, TC_NONE, 8'd0, 16'd0, 1'b1);
        send_event(OP_TRIGGER, TC_SENSOR, RST_FAULT_SEV - 8'd1, 16'd0, 1'b1);
        // healthy warning recovers to safe
        send_event(OP_TICK, TC_NONE, 8'd0, 16'd0, 1'b1);
        send_event(OP_TRIGGER, TC_SYSTEM, 8'hFF, 16'd0, 1'b1);
    endtask

    task automatic send_random();
        int          pick;
        logic [1:0]  op;
        logic [3:0]  code;
        logic [7:0]  sev;
        logic [15:0] ms;
        logic        ok;
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = OP_TICK;
        else if (pick < 85) op = OP_TRIGGER;
        else if (pick < 95) op = OP_MAN_RESET;
        else                op = OP_INIT_DONE;
        if ($urandom_range(0, 6) == 0) code = 4'($urandom_range(TC_FIRST_BAD, TC_LAST_BAD));
        else                           code = 4'($urandom_range(TC_NONE, TC_SYSTEM));
        // half of the severities land on a threshold or its neighbors
        case ($urandom_range(0, 3))
            0:       sev = 8'(crit_now + 8'($urandom_range(0, 2)) - 8'd1);
            1:       sev = 8'(fault_now + 8'($urandom_range(0, 2)) - 8'd1);
            default: sev = 8'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0:       ms = 16'($urandom);
            1:       ms = 16'($urandom_range(0, 2000));
            default: ms = 16'($urandom_range(0, 20));
        endcase
        ok = ($urandom_range(0, 4) != 0);
        send_event(op, code, sev, ms, ok);
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: program_regs('0, '0, '0, 8'd1, 8'd0, 8'd0);
                1: program_regs('1, '1, '1, 8'hFF, 8'hFF, 8'hFF);
                2: program_regs(RST_INIT_TO, RST_WARN_TO, RST_STOP_TO,
                                RST_MAX_RECOV, RST_CRIT_SEV, RST_FAULT_SEV);
                default: program_regs($urandom_range(0, 70000), $urandom_range(0, 70000),
                                      $urandom_range(0, 70000), 8'($urandom_range(1, 255)),
                                      8'($urandom), 8'($urandom));
            endcase
            quiet = (ph == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2) drain();
                if (ph == 6 && n == 40) choke_req++;
                send_random();
            end
        end
        drain();
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("failsafe_escalation_controller verification clean");
        else
            $display("failsafe_escalation_controller verification failed");
        $finish;
    end

endmodule
